// ===== src/cd_pkg.sv =====
// Shared types, codes and constants of the coherence directory.
`timescale 1ns / 1ps
`default_nettype none
package cd_pkg;

  localparam int unsigned CdNumCaches  = 8;
  localparam int unsigned CdDirEntries = 256;
  localparam int unsigned AddrBits     = 48;

  localparam logic [31:0] SeedReset = 32'd69369601;
  localparam logic [31:0] LfsrTaps  = 32'h80200003;

  typedef enum logic [2:0] {
    OP_ACCESS   = 3'd0,
    OP_SREQ     = 3'd1,
    OP_SREPLY   = 3'd2,
    OP_PREPLY   = 3'd3,
    OP_EVICT    = 3'd4,
    OP_CHECK    = 3'd5,
    OP_DROP     = 3'd6,
    OP_CLEAR    = 3'd7
  } cd_op_e;

  typedef enum logic [2:0] {
    STAT_NONE      = 3'd0,
    STAT_BUSY      = 3'd1,
    STAT_INVAL     = 3'd2,
    STAT_WRITEBACK = 3'd3,
    STAT_TRANSFER  = 3'd4,
    STAT_SFETCH    = 3'd5,
    STAT_UNREG     = 3'd6,
    STAT_FULL      = 3'd7
  } cd_status_e;

  localparam logic [1:0] AtInst  = 2'd0;
  localparam logic [1:0] AtExcl  = 2'd2;

  localparam logic [1:0] CfgApplyEvict = 2'd0;
  localparam logic [1:0] CfgPrefer     = 2'd1;
  localparam logic [1:0] CfgSeed       = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_PICK,
    S_EMIT
  } cd_state_e;

  typedef enum logic [1:0] {
    PK_IDLE,
    PK_DIV,
    PK_SEL
  } cd_pick_state_e;

  typedef struct packed {
    logic [2:0]          operation;
    logic [AddrBits-1:0] block_address;
    logic [2:0]          cache_num;
    logic [1:0]          access_kind;
    logic                dirty;
    logic                writeable;
  } cd_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       grant_writeable;
    logic       invalidate_needed;
    logic       peer_valid;
    logic [2:0] wait_peer;
    logic       final_reply;
    logic       holder_ok;
    logic       last;
  } cd_rsp_t;

endpackage
`default_nettype wire

// ===== src/coherence_directory.sv =====
// Top level of the coherence directory: command port, entry lookup and result sequencing.
`timescale 1ns / 1ps
`default_nettype none
// A command is taken when start is high and busy is low. Every command except
// clear all (and a command other than drop with a cache id outside the
// configured range) walks the whole entry memory, one entry per cycle, to find
// the block and the lowest free entry before its first result; clear all and
// out-of-range ids give their result in the cycle after the command. An access
// that must wait for peers then scans the cache id positions in ascending
// order, with result beats only on positions that are waited for. A shared
// read that picks a neighbor first reduces a random value modulo the count of
// other sharers, then walks the cache id positions up to the chosen peer.
// Results appear for one cycle with rsp_valid_o; the receiver cannot stall
// them, and last marks the final beat of a command. Entry valid bits are
// flip-flops cleared at reset, so no clearing pass is needed.
// Configuration writes are taken while busy is low.
module coherence_directory #(
  parameter int unsigned NUM_CACHES  = cd_pkg::CdNumCaches,
  parameter int unsigned DIR_ENTRIES = cd_pkg::CdDirEntries
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire cd_pkg::cd_req_t req_i,
  output logic                 rsp_valid_o,
  output cd_pkg::cd_rsp_t      rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);
  import cd_pkg::*;

  localparam int unsigned N   = NUM_CACHES;
  localparam int unsigned IW  = $clog2(DIR_ENTRIES);
  localparam int unsigned CW  = $clog2(DIR_ENTRIES + 1);
  localparam int unsigned KW  = $clog2(N);
  localparam int unsigned EW  = AddrBits + 2 + 2 * N;

  cd_state_e            state_q, state_d;
  cd_req_t              req_q, req_d;
  logic [DIR_ENTRIES-1:0] used_q, used_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [IW-1:0]        pidx_q, pidx_d;
  logic                 hit_q, hit_d;
  logic [IW-1:0]        hidx_q, hidx_d;
  logic [EW-1:0]        hdata_q, hdata_d;
  logic                 free_q, free_d;
  logic [IW-1:0]        fidx_q, fidx_d;
  logic [31:0]          lfsr_q, lfsr_d;
  logic                 evict_q, evict_d;
  logic                 prefer_q, prefer_d;
  cd_rsp_t              base_q, base_d;
  logic [N-1:0]         rem_q, rem_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 rvalid_q, rvalid_d;
  cd_rsp_t              rsp_q, rsp_d;

  // Memory and picker hookups.
  logic                 re;
  logic [IW-1:0]        raddr;
  logic [EW-1:0]        rdata;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic                 pick_start;
  logic [31:0]          pick_div;
  logic [N-1:0]         pick_cand;
  logic                 pick_done;
  logic [KW-1:0]        pick_sel;

  // Fields of the entry that was found.
  logic [AddrBits-1:0]  e_addr;
  logic                 e_excl;
  logic [N-1:0]         e_hold;
  logic [N-1:0]         e_wait;
  logic                 e_sb;
  logic [N-1:0]         req_bit;
  logic [N-1:0]         others;
  logic [N-1:0]         waits;
  logic [N-1:0]         n_hold;
  logic [N-1:0]         n_wait;
  logic                 n_excl;
  logic                 n_sb;
  logic                 e_busy;
  logic                 ok;
  logic [N-1:0]         rem_nx;
  logic [31:0]          lfsr_nx;
  cd_rsp_t              r;

  cd_ram #(
    .Depth (DIR_ENTRIES),
    .Width (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cd_pick #(
    .NumCaches (N)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pick_start),
    .dividend_i (pick_div),
    .cand_i     (pick_cand),
    .done_o     (pick_done),
    .sel_o      (pick_sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      pend_q   <= 1'b0;
      lfsr_q   <= SeedReset;
      evict_q  <= 1'b0;
      prefer_q <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      pend_q   <= pend_d;
      lfsr_q   <= lfsr_d;
      evict_q  <= evict_d;
      prefer_q <= prefer_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cnt_q   <= cnt_d;
    pidx_q  <= pidx_d;
    hit_q   <= hit_d;
    hidx_q  <= hidx_d;
    hdata_q <= hdata_d;
    free_q  <= free_d;
    fidx_q  <= fidx_d;
    base_q  <= base_d;
    rem_q   <= rem_d;
    k_q     <= k_d;
    rsp_q   <= rsp_d;
  end

  always_comb begin
    e_sb   = hdata_q[0];
    e_wait = hdata_q[N:1];
    e_hold = hdata_q[2*N:N+1];
    e_excl = hdata_q[2*N+1];
    e_addr = hdata_q[EW-1:2*N+2];
    req_bit = {{(N-1){1'b0}}, 1'b1} << req_q.cache_num;
    others = e_hold & ~req_bit;
    e_busy = (|e_wait) | e_sb;
    lfsr_nx = lfsr_q >> 1;
    if (lfsr_q[0]) begin
      lfsr_nx = lfsr_nx ^ LfsrTaps;
    end
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    used_d   = used_q;
    cnt_d    = cnt_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    hit_d    = hit_q;
    hidx_d   = hidx_q;
    hdata_d  = hdata_q;
    free_d   = free_q;
    fidx_d   = fidx_q;
    lfsr_d   = lfsr_q;
    evict_d  = evict_q;
    prefer_d = prefer_q;
    base_d   = base_q;
    rem_d    = rem_q;
    k_d      = k_q;
    rvalid_d = 1'b0;
    rsp_d    = rsp_q;
    re       = 1'b0;
    raddr    = cnt_q[IW-1:0];
    we       = 1'b0;
    waddr    = hidx_q;
    wdata    = hdata_q;
    pick_start = 1'b0;
    pick_div   = lfsr_nx;
    pick_cand  = others;
    waits    = '0;
    n_hold   = e_hold;
    n_wait   = e_wait;
    n_excl   = e_excl;
    n_sb     = e_sb;
    ok       = 1'b0;
    rem_nx   = rem_q;
    r        = '0;
    r.last   = 1'b1;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgApplyEvict: evict_d  = cfg_data_i[0];
        CfgPrefer:     prefer_d = cfg_data_i[0];
        CfgSeed:       lfsr_d   = (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
        default:       ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          if (req_i.operation == OP_CLEAR) begin
            used_d   = '0;
            rvalid_d = 1'b1;
            rsp_d    = r;
          end else if (req_i.operation != OP_DROP &&
                       32'(req_i.cache_num) >= N) begin
            rvalid_d = 1'b1;
            rsp_d    = r;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read one entry per cycle and check the one read last cycle.
        re = (cnt_q < CW'(DIR_ENTRIES));
        if (re) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d  = cnt_q + CW'(1);
        end
        if (pend_q) begin
          if (used_q[pidx_q] && rdata[EW-1:2*N+2] == req_q.block_address && !hit_q) begin
            hit_d   = 1'b1;
            hidx_d  = pidx_q;
            hdata_d = rdata;
          end
          if (!used_q[pidx_q] && !free_q) begin
            free_d = 1'b1;
            fidx_d = pidx_q;
          end
        end
        if (!re && !pend_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d = S_IDLE;
        case (req_q.operation)
          OP_DROP: begin
            if (hit_q) begin
              used_d[hidx_q] = 1'b0;
            end
          end
          OP_ACCESS: begin
            if (!hit_q) begin
              if (!free_q) begin
                r.status = STAT_FULL;
              end else begin
                // Allocate the lowest free entry for this block.
                used_d[fidx_q] = 1'b1;
                we    = 1'b1;
                waddr = fidx_q;
                wdata = {req_q.block_address, req_q.access_kind != AtInst,
                         req_bit, {N{1'b0}}, 1'b0};
                r.grant_writeable = (req_q.access_kind != AtInst);
              end
            end else if (e_busy) begin
              r.status = STAT_BUSY;
            end else if (!e_excl) begin
              if (req_q.access_kind == AtExcl) begin
                // Upgrade to exclusive; all other sharers must invalidate.
                if (|others) begin
                  r.status = ((e_hold & req_bit) != '0) ? STAT_INVAL : STAT_TRANSFER;
                  waits    = others;
                  r.invalidate_needed = 1'b1;
                end
                n_wait = others;
                n_hold = req_bit;
                n_excl = 1'b1;
                r.grant_writeable = 1'b1;
                we = 1'b1;
              end else if (prefer_q && (|others)) begin
                // Fetch from a random sharer; the write happens once picked.
                lfsr_d     = lfsr_nx;
                pick_start = 1'b1;
                hdata_d    = {e_addr, e_excl, e_hold | req_bit, e_wait, e_sb};
                state_d    = S_PICK;
              end else begin
                n_hold = e_hold | req_bit;
                we     = 1'b1;
              end
            end else if (e_hold != req_bit) begin
              waits = others;
              if (req_q.access_kind == AtExcl) begin
                r.status = STAT_TRANSFER;
                r.invalidate_needed = 1'b1;
                r.grant_writeable   = 1'b1;
                n_hold = req_bit;
              end else begin
                r.status = STAT_WRITEBACK;
                n_hold = e_hold | req_bit;
                n_excl = 1'b0;
              end
              n_wait = others;
              if (others == '0) begin
                r.status = STAT_NONE;
                r.invalidate_needed = 1'b0;
              end
              we = 1'b1;
            end else begin
              r.grant_writeable = 1'b1;
            end
            if (we && hit_q) begin
              wdata = {e_addr, n_excl, n_hold, n_wait, n_sb};
            end
          end
          default: begin
            if (!hit_q) begin
              r.status = STAT_UNREG;
            end else begin
              case (req_q.operation)
                OP_SREQ: begin
                  if (e_busy) begin
                    r.status = STAT_BUSY;
                  end else begin
                    n_sb = 1'b1;
                    we   = 1'b1;
                  end
                end
                OP_SREPLY: begin
                  n_sb = 1'b0;
                  we   = 1'b1;
                end
                OP_PREPLY: begin
                  if ((e_wait & req_bit) != '0) begin
                    n_wait        = e_wait & ~req_bit;
                    r.final_reply = (n_wait == '0);
                    we            = 1'b1;
                  end
                end
                OP_EVICT: begin
                  if ((e_wait & req_bit) == '0 && (e_hold & req_bit) != '0 && evict_q) begin
                    n_hold = e_hold & ~req_bit;
                    we     = 1'b1;
                    if (n_hold == '0) begin
                      used_d[hidx_q] = 1'b0;
                    end
                  end
                end
                OP_CHECK: begin
                  if ((e_hold & req_bit) == '0) begin
                    ok = 1'b0;
                  end else if (!e_excl) begin
                    ok = !req_q.dirty && !req_q.writeable;
                  end else begin
                    ok = 1'b1;
                  end
                  if ((e_wait & req_bit) != '0) begin
                    ok = 1'b1;
                  end
                  r.holder_ok = ok;
                end
                default: ;
              endcase
              wdata = {e_addr, n_excl, n_hold, n_wait, n_sb};
            end
          end
        endcase
        if (state_d == S_IDLE) begin
          if (waits != '0) begin
            // Waited peers go out one beat each, in ascending cache id.
            base_d  = r;
            rem_d   = waits;
            k_d     = '0;
            state_d = S_EMIT;
          end else begin
            rvalid_d = 1'b1;
            rsp_d    = r;
          end
        end
      end

      S_PICK: begin
        if (pick_done) begin
          n_wait = {{(N-1){1'b0}}, 1'b1} << pick_sel;
          we     = 1'b1;
          wdata  = {e_addr, e_excl, e_hold, n_wait, e_sb};
          base_d = '0;
          base_d.status = STAT_SFETCH;
          rem_d   = n_wait;
          k_d     = '0;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        k_d = k_q + KW'(1);
        if (rem_q[k_q]) begin
          rem_nx       = rem_q & ~({{(N-1){1'b0}}, 1'b1} << k_q);
          rem_d        = rem_nx;
          r            = base_q;
          r.peer_valid = 1'b1;
          r.wait_peer  = 3'(k_q);
          r.last       = (rem_nx == '0);
          rvalid_d     = 1'b1;
          rsp_d        = r;
          if (rem_nx == '0) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rvalid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

// ===== src/cd_ram.sv =====
// Directory entry memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module cd_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 66
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/cd_pick.sv =====
// Serial neighbor picker: lfsr mod candidate count, then walk to that candidate.
`timescale 1ns / 1ps
`default_nettype none
module cd_pick #(
  parameter int unsigned NumCaches = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [31:0]                  dividend_i,
  input  wire logic [NumCaches-1:0]         cand_i,
  output logic                              done_o,
  output logic      [$clog2(NumCaches)-1:0] sel_o
);
  import cd_pkg::*;

  localparam int unsigned CntW = $clog2(NumCaches + 1);
  localparam int unsigned RemW = CntW + 1;
  localparam int unsigned KW   = $clog2(NumCaches);

  cd_pick_state_e         state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [31:0]            dq_q, dq_d;
  logic [4:0]             step_q, step_d;
  logic [NumCaches-1:0]   cand_q, cand_d;
  logic [KW-1:0]          k_q, k_d;
  logic                   done_q, done_d;
  logic [KW-1:0]          sel_q, sel_d;
  logic [RemW-1:0]        trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    step_q <= step_d;
    cand_q <= cand_d;
    k_q    <= k_d;
    sel_q  <= sel_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    step_d  = step_q;
    cand_d  = cand_q;
    k_d     = k_q;
    sel_d   = sel_q;
    done_d  = 1'b0;
    trial   = {rem_q[RemW-2:0], dq_q[31]};
    case (state_q)
      PK_IDLE: begin
        if (start_i) begin
          cnt_d   = CntW'($countones(cand_i));
          cand_d  = cand_i;
          dq_d    = dividend_i;
          rem_d   = '0;
          step_d  = '0;
          state_d = PK_DIV;
        end
      end
      PK_DIV: begin
        // One restoring step per cycle; the remainder stays below the count.
        if (trial >= {1'b0, cnt_q}) begin
          rem_d = trial - {1'b0, cnt_q};
        end else begin
          rem_d = trial;
        end
        dq_d   = {dq_q[30:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          k_d     = '0;
          state_d = PK_SEL;
        end
      end
      PK_SEL: begin
        if (cand_q[k_q]) begin
          if (rem_q == '0) begin
            sel_d   = k_q;
            done_d  = 1'b1;
            state_d = PK_IDLE;
          end else begin
            rem_d = rem_q - RemW'(1);
          end
        end
        k_d = k_q + KW'(1);
      end
      default: begin
        state_d = PK_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign sel_o  = sel_q;

endmodule
`default_nettype wire
